FILE: hdl/abvm_pkg.sv
`default_nettype none
package abvm_pkg;

	localparam int NUM_DIMS    = 5;
	localparam int VEC_W       = 6;
	localparam int WORD_W      = 5;
	localparam int BIT_W       = 5;
	localparam int FILT_W      = WORD_W + BIT_W;
	localparam int CNT_W       = FILT_W + 1;
	localparam int CHUNK_BITS  = 1 << BIT_W;
	localparam int VECS        = 1 << VEC_W;
	localparam int MAP_AW      = VEC_W + WORD_W;
	localparam int MAP_DEPTH   = 1 << MAP_AW;
	localparam int MAX_FILTERS = 1 << FILT_W;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_SET    = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic load;
		logic agg_rd;
		logic map_rd;
		logic scan;
		logic set_wr;
		logic clr;
		logic r_load;
		logic r_clr;
		logic out_load;
		logic out_found;
		logic out_rej;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic ok;
		logic all_present;
		logic r_zero;
		logic m_hit;
		logic m_stop;
		logic out_free;
	} sts_t;

	function automatic logic [BIT_W-1:0] low_bit(input logic [CHUNK_BITS-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
			if (v[i]) r = BIT_W'(i);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/aggregated_bit_vector_match.sv
// Aggregated bit vector filter match.
// Requests enter on the s_ stream: s_tuser carries the opcode (clear vector,
// set filter bit, lookup), s_tdata the vector selectors and filter index.
// One response per request leaves on the m_ stream: m_tuser = {rejected,
// found}, m_tdata = best_filter.
// cfg_valid/cfg_data write filter_count; cfg_ready is always high. Write it
// only while no request is in flight.
// Clear, rejected set and lookup with an absent dimension respond straight
// after the RAM read; set writes the RAMs first. Lookup walks candidate map
// words until a hit, until the walk reaches filter_count, or until the
// candidates run out (at most 32 words).
// One request is in service at a time; the next is taken the cycle after a
// response enters the output register. The candidate walk reads one map
// word per dimension in each scan and evaluate step.
// Reset clears filter_count and every vector's valid bits at once, so all
// aggregates read as zero; map RAMs need no clearing.
// A stalled m_tready holds the response; the block then finishes at most
// one more request and waits with it until the output register frees.
`default_nettype none
module aggregated_bit_vector_match (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// dimension, vector_id, filter_index, sel_protocol, sel_src_addr,
	// sel_dst_addr, sel_dst_port, sel_src_port, present_mask
	input  wire logic [55:0]                 s_tdata,
	// opcode
	input  wire logic [1:0]                  s_tuser,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// best_filter
	output logic [15:0]                      m_tdata,
	// found, rejected
	output logic [1:0]                       m_tuser,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [abvm_pkg::CNT_W-1:0]  cfg_data
);
	import abvm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	abvm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	abvm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire

FILE: hdl/abvm_ram.sv
`default_nettype none
module abvm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: hdl/abvm_ctrl.sv
`default_nettype none
module abvm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire abvm_pkg::sts_t  sts,
	output abvm_pkg::cmd_t       cmd
);
	import abvm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_EVAL, ST_SCAN, ST_MEVAL, ST_RES_ZERO, ST_RES_REJ
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_RD;
				end
			end
			ST_RD: begin
				cmd.agg_rd = 1'b1;
				cmd.map_rd = 1'b1;
				unique case (sts.op)
					OP_CLEAR: begin
						cmd.clr = 1'b1;
						state_d = ST_RES_ZERO;
					end
					OP_SET:    state_d = sts.ok ? ST_EVAL : ST_RES_REJ;
					OP_LOOKUP: state_d = sts.all_present ? ST_EVAL : ST_RES_ZERO;
					default:   state_d = ST_RES_ZERO;
				endcase
			end
			ST_EVAL: begin
				if (sts.op == OP_SET) begin
					cmd.set_wr = 1'b1;
					state_d    = ST_RES_ZERO;
				end else begin
					cmd.r_load = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.r_zero) begin
					state_d = ST_RES_ZERO;
				end else begin
					cmd.scan   = 1'b1;
					cmd.map_rd = 1'b1;
					state_d    = ST_MEVAL;
				end
			end
			ST_MEVAL: begin
				priority if (sts.m_hit) begin
					if (sts.out_free) begin
						cmd.out_load  = 1'b1;
						cmd.out_found = 1'b1;
						state_d       = ST_IDLE;
					end
				end else if (sts.m_stop) begin
					state_d = ST_RES_ZERO;
				end else begin
					cmd.r_clr = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_RES_ZERO: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_RES_REJ: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_rej  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

FILE: hdl/abvm_dp.sv
`default_nettype none
module abvm_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [55:0]                    s_tdata,
	input  wire logic [1:0]                     s_tuser,
	input  wire logic                           cfg_valid,
	input  wire logic [abvm_pkg::CNT_W-1:0]     cfg_data,
	input  wire abvm_pkg::cmd_t                 cmd,
	output abvm_pkg::sts_t                      sts,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [15:0]                         m_tdata,
	output logic [1:0]                          m_tuser
);
	import abvm_pkg::*;

	op_t                op_q;
	logic [2:0]         dim_q;
	logic [VEC_W-1:0]   vid_q;
	logic [FILT_W-1:0]  fi_q;
	logic [VEC_W-1:0]   sel_q [NUM_DIMS];
	logic [NUM_DIMS-1:0] mask_q;
	logic [CNT_W-1:0]   fc_q;
	logic [VECS-1:0]    vld_q [NUM_DIMS];
	logic [CHUNK_BITS-1:0] r_q;
	logic [WORD_W-1:0]  w_q;
	logic               out_vld_q, found_q, rej_q;
	logic [FILT_W-1:0]  best_q;

	logic [CHUNK_BITS-1:0] agg_rdata [NUM_DIMS];
	logic [CHUNK_BITS-1:0] map_rdata [NUM_DIMS];
	logic [CHUNK_BITS-1:0] aggv [NUM_DIMS];
	logic [NUM_DIMS-1:0]   vld_set;
	logic [NUM_DIMS-1:0]   vld_lk;

	logic [CNT_W-1:0]      cnt;
	logic [WORD_W-1:0]     wsel;
	logic [WORD_W-1:0]     fw;
	logic [BIT_W-1:0]      fb;
	logic [CHUNK_BITS-1:0] r_all, m_all, cmask, mm;
	logic [CNT_W-BIT_W-1:0] hi;
	logic [CNT_W-BIT_W-1:0] wx;

	assign cnt  = fc_q[CNT_W-1] ? CNT_W'(MAX_FILTERS) : fc_q;
	assign wsel = low_bit(r_q);
	assign fw   = fi_q[FILT_W-1:BIT_W];
	assign fb   = fi_q[BIT_W-1:0];
	assign hi   = cnt[CNT_W-1:BIT_W];
	assign wx   = {1'b0, w_q};

	genvar d;
	generate
		for (d = 0; d < NUM_DIMS; d++) begin : g_dim
			logic              sel_dim;
			logic              had;
			logic [VEC_W-1:0]  agg_ra;
			logic [MAP_AW-1:0] map_ra;

			assign sel_dim    = (dim_q == 3'(d));
			assign vld_set[d] = vld_q[d][vid_q];
			assign vld_lk[d]  = vld_q[d][sel_q[d]];
			assign agg_ra     = (op_q == OP_LOOKUP) ? sel_q[d] : vid_q;
			assign map_ra     = (op_q == OP_LOOKUP) ? {sel_q[d], wsel} : {vid_q, fw};
			assign aggv[d]    = vld_set[d] ? agg_rdata[d] : '0;
			assign had        = aggv[d][fw];

			abvm_ram #(.WIDTH(CHUNK_BITS), .DEPTH(VECS)) u_agg (
				.clk   (clk),
				.we    (cmd.set_wr && sel_dim),
				.waddr (vid_q),
				.wdata (aggv[d] | (CHUNK_BITS'(1) << fw)),
				.re    (cmd.agg_rd),
				.raddr (agg_ra),
				.rdata (agg_rdata[d])
			);

			abvm_ram #(.WIDTH(CHUNK_BITS), .DEPTH(MAP_DEPTH)) u_map (
				.clk   (clk),
				.we    (cmd.set_wr && sel_dim),
				.waddr ({vid_q, fw}),
				.wdata ((had ? map_rdata[d] : '0) | (CHUNK_BITS'(1) << fb)),
				.re    (cmd.map_rd),
				.raddr (map_ra),
				.rdata (map_rdata[d])
			);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[d] <= '0;
				end else if (sel_dim && cmd.clr) begin
					vld_q[d][vid_q] <= 1'b0;
				end else if (sel_dim && cmd.set_wr) begin
					vld_q[d][vid_q] <= 1'b1;
				end
			end
		end
	endgenerate

	always_comb begin
		r_all = '1;
		m_all = '1;
		for (int i = 0; i < NUM_DIMS; i++) begin
			r_all = r_all & (vld_lk[i] ? agg_rdata[i] : '0);
			m_all = m_all & map_rdata[i];
		end
	end

	always_comb begin
		priority if (hi > wx) cmask = '1;
		else if (hi == wx) cmask = (CHUNK_BITS'(1) << cnt[BIT_W-1:0]) - CHUNK_BITS'(1);
		else cmask = '0;
	end

	assign mm = m_all & cmask;

	assign sts.op          = op_q;
	assign sts.ok          = (dim_q < 3'(NUM_DIMS)) && ({1'b0, fi_q} < cnt);
	assign sts.all_present = &mask_q;
	assign sts.r_zero      = (r_q == '0);
	assign sts.m_hit       = |mm;
	assign sts.m_stop      = (hi <= wx);
	assign sts.out_free    = !out_vld_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(s_tuser);
			dim_q    <= s_tdata[2:0];
			vid_q    <= s_tdata[8:3];
			fi_q     <= s_tdata[18:9];
			sel_q[0] <= s_tdata[24:19];
			sel_q[1] <= s_tdata[30:25];
			sel_q[2] <= s_tdata[36:31];
			sel_q[3] <= s_tdata[42:37];
			sel_q[4] <= s_tdata[48:43];
			mask_q   <= s_tdata[53:49];
		end
		if (cmd.r_load) r_q <= r_all;
		else if (cmd.r_clr) r_q <= r_q & ~(CHUNK_BITS'(1) << w_q);
		if (cmd.scan) w_q <= wsel;
		if (cmd.out_load) begin
			found_q <= cmd.out_found;
			rej_q   <= cmd.out_rej;
			best_q  <= cmd.out_found ? {w_q, low_bit(mm)} : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_valid) fc_q <= cfg_data;
			if (cmd.out_load) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'd0, best_q};
	assign m_tuser  = {rej_q, found_q};

endmodule
`default_nettype wire
